/* src/itrs_pkg.sv */
// ----------------------------------------------------------------------------
// itrs_pkg - shared definitions for the radix string converter
// Widths, character codes, state encoding and small helper functions.
// ----------------------------------------------------------------------------
package itrs_pkg;

    // Input integer width and derived widths
    localparam int VALUE_BITS = 32;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS);
    localparam int STK_CNT_W  = $clog2(VALUE_BITS + 1);

    // Digit, remainder and character widths
    localparam int DIGIT_W = 6;
    localparam int REM_W   = DIGIT_W + 1;
    localparam int BASE_W  = 6;
    localparam int CHAR_W  = 7;
    localparam int TDATA_W = 8;

    // Base register limits
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;

    // Digit values around the letter boundary
    localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_X     = 7'h78;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2d;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_PRE0,
        ST_PREX,
        ST_DIGIT
    } state_t;

    // Divider status towards the sequencer and the digit stack
    typedef struct packed {
        logic               busy;
        logic               digit_valid;
        logic               final_digit;
        logic [DIGIT_W-1:0] digit;
    } div_status_t;

    // Digit stack control
    typedef struct packed {
        logic push;
        logic pop;
    } stk_ctrl_t;

    // Clamp the written base into 2..36
    function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        if (b < BASE_MIN)
            r = BASE_MIN;
        else if (b > BASE_MAX)
            r = BASE_MAX;
        else
            r = b;
        return r;
    endfunction

    // Digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= DIGIT_NINE)
            c = CHAR_ZERO + CHAR_W'(d);
        else
            c = CHAR_A + CHAR_W'(d - DIGIT_TEN);
        return c;
    endfunction

endpackage

/* src/integer_to_radix_string.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_string - signed integer to ASCII text in base 2..36
// Emits '-' for a negative value, then "0x" in base 16, then the digits, one
// character per transfer, most significant first, with tlast on the final character.
// ----------------------------------------------------------------------------
//  Channel   | Signals                                   | Contents
//  ----------+-------------------------------------------+---------------------
//  input     | s_tvalid, s_tready, s_tdata[31:0]         | value (signed)
//  output    | m_tvalid, m_tready, m_tdata[7:0], m_tlast | ascii_char, last
//  config    | cfg_wen, cfg_wdata[5:0]                   | base (reset 10)
//
//  The bit-serial divider produces one quotient bit per cycle, one full pass per digit;
//  characters then leave one per cycle from the output register while m_tready is high.
//  Reset clears control state only; no clearing pass is needed.
//  A stalled output holds the sequencer; the next value is taken as soon as
//  the final character is loaded into the output register.
// ----------------------------------------------------------------------------
module integer_to_radix_string
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [itrs_pkg::VALUE_BITS-1:0]   s_tdata,   // [31:0] value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [itrs_pkg::TDATA_W-1:0]      m_tdata,   // [6:0] ascii_char, [7] zero
    output logic                              m_tlast,
    input  logic                              cfg_wen,
    input  logic [itrs_pkg::BASE_W-1:0]       cfg_wdata
);

    itrs_pkg::state_t                  state_reg, state_next;
    logic [itrs_pkg::BASE_W-1:0]       base_reg;
    logic [itrs_pkg::BASE_W-1:0]       base_eff;
    logic                              hex;
    logic                              neg_reg;
    logic                              in_xfer;
    logic [itrs_pkg::VALUE_BITS-1:0]   mag;
    itrs_pkg::div_status_t             div_st;
    itrs_pkg::stk_ctrl_t               stk_ctrl;
    logic [itrs_pkg::DIGIT_W-1:0]      stk_top;
    logic [itrs_pkg::STK_CNT_W-1:0]    stk_count;
    logic                              out_free;
    logic                              load;
    logic [itrs_pkg::CHAR_W-1:0]       load_char;
    logic                              load_last;
    logic                              m_tvalid_reg;
    logic [itrs_pkg::CHAR_W-1:0]       m_char_reg;
    logic                              m_tlast_reg;

    // Base register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= itrs_pkg::BASE_RESET;
        else if (cfg_wen)
            base_reg <= cfg_wdata;
    end

    assign base_eff = itrs_pkg::eff_base(base_reg);
    assign hex      = (base_eff == itrs_pkg::BASE_HEX);

    // Input transfer and magnitude
    assign s_tready = (state_reg == itrs_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign mag      = s_tdata[itrs_pkg::VALUE_BITS-1] ? (~s_tdata + 1'b1) : s_tdata;

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            neg_reg <= s_tdata[itrs_pkg::VALUE_BITS-1];
    end

    itrs_divider u_divider
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (in_xfer),
        .mag    (mag),
        .base   (base_eff),
        .status (div_st)
    );

    itrs_stack u_stack
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stk_ctrl),
        .push_digit (div_st.digit),
        .top        (stk_top),
        .count      (stk_count)
    );

    // Sequencer: next state and character selection
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        load          = 1'b0;
        load_char     = itrs_pkg::CHAR_ZERO;
        load_last     = 1'b0;
        stk_ctrl.push = div_st.digit_valid;
        stk_ctrl.pop  = 1'b0;
        case (state_reg)
            itrs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                    state_next = itrs_pkg::ST_DIV;
            end
            itrs_pkg::ST_DIV:
            begin
                if (div_st.final_digit)
                begin
                    if (neg_reg)
                        state_next = itrs_pkg::ST_SIGN;
                    else if (hex)
                        state_next = itrs_pkg::ST_PRE0;
                    else
                        state_next = itrs_pkg::ST_DIGIT;
                end
            end
            itrs_pkg::ST_SIGN:
            begin
                load_char = itrs_pkg::CHAR_MINUS;
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = hex ? itrs_pkg::ST_PRE0 : itrs_pkg::ST_DIGIT;
                end
            end
            itrs_pkg::ST_PRE0:
            begin
                load_char = itrs_pkg::CHAR_ZERO;
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = itrs_pkg::ST_PREX;
                end
            end
            itrs_pkg::ST_PREX:
            begin
                load_char = itrs_pkg::CHAR_X;
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = itrs_pkg::ST_DIGIT;
                end
            end
            itrs_pkg::ST_DIGIT:
            begin
                load_char = itrs_pkg::digit_char(stk_top);
                load_last = (stk_count == itrs_pkg::STK_CNT_W'(1));
                if (out_free)
                begin
                    load         = 1'b1;
                    stk_ctrl.pop = 1'b1;
                    if (load_last)
                        state_next = itrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = itrs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= itrs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_char_reg  <= load_char;
            m_tlast_reg <= load_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_tlast_reg;

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n) s_tready |-> !div_st.busy)
        else $error("input ready while divider busy");

    assert property (@(posedge clk) disable iff (!rst_n) in_xfer |=> div_st.busy)
        else $error("divider did not start on input transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == itrs_pkg::ST_DIGIT) |-> (stk_count != '0))
        else $error("digit stack empty while emitting digits");

    assert property (@(posedge clk) disable iff (!rst_n)
        (stk_ctrl.push && stk_ctrl.pop) |-> 1'b0)
        else $error("digit stack pushed and popped together");

endmodule

/* src/itrs_divider.sv */
// ----------------------------------------------------------------------------
// itrs_divider - bit-serial radix divider
// Restoring division of the magnitude by the base, one quotient bit per
// cycle. Each pass yields one digit; passes repeat until the quotient is zero.
// ----------------------------------------------------------------------------
module itrs_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [itrs_pkg::VALUE_BITS-1:0]   mag,
    input  logic [itrs_pkg::BASE_W-1:0]       base,
    output itrs_pkg::div_status_t             status
);

    localparam logic [itrs_pkg::BIT_CNT_W-1:0] LAST_BIT =
        itrs_pkg::BIT_CNT_W'(itrs_pkg::VALUE_BITS - 1);

    logic                                busy_reg,     busy_next;
    logic [itrs_pkg::BIT_CNT_W-1:0]      bit_cnt_reg,  bit_cnt_next;
    logic [itrs_pkg::VALUE_BITS-1:0]     dvd_reg,      dvd_next;
    logic [itrs_pkg::DIGIT_W-1:0]        rem_reg,      rem_next;
    logic [itrs_pkg::REM_W-1:0]          trial;
    logic                                qbit;
    logic                                pass_end;

    // One restoring step: bring down the next dividend bit, compare, subtract
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[itrs_pkg::VALUE_BITS-1]};
        qbit     = (trial >= {1'b0, base});
        rem_next = qbit ? itrs_pkg::DIGIT_W'(trial - {1'b0, base})
                        : itrs_pkg::DIGIT_W'(trial);
        dvd_next = {dvd_reg[itrs_pkg::VALUE_BITS-2:0], qbit};
        pass_end = busy_reg && (bit_cnt_reg == LAST_BIT);
    end

    // Pass and bit sequencing
    always_comb
    begin
        busy_next    = busy_reg;
        bit_cnt_next = bit_cnt_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            bit_cnt_next = '0;
        end
        else if (busy_reg)
        begin
            if (pass_end)
            begin
                bit_cnt_next = '0;
                if (dvd_next == '0)
                    busy_next = 1'b0;
            end
            else
            begin
                bit_cnt_next = bit_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            bit_cnt_reg <= '0;
        end
        else
        begin
            busy_reg    <= busy_next;
            bit_cnt_reg <= bit_cnt_next;
        end
    end

    // Datapath: quotient shifts in as the dividend shifts out
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= mag;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_next;
            rem_reg <= pass_end ? '0 : rem_next;
        end
    end

    assign status.busy        = busy_reg;
    assign status.digit_valid = pass_end;
    assign status.final_digit = pass_end && (dvd_next == '0);
    assign status.digit       = rem_next;

endmodule

/* src/itrs_stack.sv */
// ----------------------------------------------------------------------------
// itrs_stack - digit reversal stack
// Shift-register LIFO: digits come in least significant first and leave
// most significant first from entry 0.
// ----------------------------------------------------------------------------
module itrs_stack
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  itrs_pkg::stk_ctrl_t               ctrl,
    input  logic [itrs_pkg::DIGIT_W-1:0]      push_digit,
    output logic [itrs_pkg::DIGIT_W-1:0]      top,
    output logic [itrs_pkg::STK_CNT_W-1:0]    count
);

    logic [itrs_pkg::DIGIT_W-1:0]   stk_reg [itrs_pkg::VALUE_BITS];
    logic [itrs_pkg::STK_CNT_W-1:0] count_reg;

    // Entry shifting
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            stk_reg[0] <= push_digit;
            for (int i = 1; i < itrs_pkg::VALUE_BITS; i++)
                stk_reg[i] <= stk_reg[i-1];
        end
        else if (ctrl.pop)
        begin
            for (int i = 0; i < itrs_pkg::VALUE_BITS - 1; i++)
                stk_reg[i] <= stk_reg[i+1];
        end
    end

    // Fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.push)
            count_reg <= count_reg + 1'b1;
        else if (ctrl.pop)
            count_reg <= count_reg - 1'b1;
    end

    assign top   = stk_reg[0];
    assign count = count_reg;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - testbench for integer_to_radix_string
// Streams signed 32-bit integers into the converter under a range of base
// settings, including the clamped ones, and checks every ASCII character and
// its tlast flag against an independent model of the conversion. Both stream
// sides idle and stall at random. A long output hold-off is also applied, to
// back up the block.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int QUIET_LIMIT    = 20000;  // cycles with no transfer at all
    localparam int HOLD_CYCLES    = 400;    // long output hold-off
    localparam int SETTLE_CYCLES  = 8;      // pause after the last character
    localparam int RAND_PHASES    = 12;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int MAX_REPORTS    = 40;

    // One expected character of the output text
    typedef struct packed {
        logic [itrs_pkg::CHAR_W-1:0] ch;
        logic                        last;
    } text_char_t;

    // Directed entry: base to use and the value to convert
    typedef struct packed {
        logic [itrs_pkg::BASE_W-1:0]     base;
        logic [itrs_pkg::VALUE_BITS-1:0] value;
    } directed_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the text of each accepted value, checks characters
    // ------------------------------------------------------------------------
    class radix_text_board;
        logic [itrs_pkg::BASE_W-1:0] base_reg;
        text_char_t                  chars_due[$];
        int                          errors;

        function new();
            base_reg = itrs_pkg::BASE_RESET;
            errors   = 0;
        endfunction

        function void set_base(input logic [itrs_pkg::BASE_W-1:0] b);
            base_reg = b;
        endfunction

        function int pending();
            return chars_due.size();
        endfunction

        // Work out the full text of one accepted value
        function void note_value(input logic [itrs_pkg::VALUE_BITS-1:0] raw);
            logic [itrs_pkg::BASE_W-1:0]     radix;
            logic [itrs_pkg::VALUE_BITS-1:0] mag;
            logic [itrs_pkg::DIGIT_W-1:0]    d;
            logic                            neg;
            logic [itrs_pkg::CHAR_W-1:0]     digits[$];
            int                              k;
            radix = base_reg;
            if (radix < itrs_pkg::BASE_MIN)
                radix = itrs_pkg::BASE_MIN;
            else if (radix > itrs_pkg::BASE_MAX)
                radix = itrs_pkg::BASE_MAX;
            neg = raw[itrs_pkg::VALUE_BITS-1];
            // two's complement negation: the most negative value stays exact
            mag = neg ? -raw : raw;
            do
            begin
                d = itrs_pkg::DIGIT_W'(mag % itrs_pkg::VALUE_BITS'(radix));
                mag = mag / itrs_pkg::VALUE_BITS'(radix);
                if (d <= itrs_pkg::DIGIT_NINE)
                    digits.push_front(itrs_pkg::CHAR_ZERO + itrs_pkg::CHAR_W'(d));
                else
                    digits.push_front(itrs_pkg::CHAR_A
                                      + itrs_pkg::CHAR_W'(d - itrs_pkg::DIGIT_TEN));
            end while (mag != 0);
            if (neg)
                chars_due.push_back({itrs_pkg::CHAR_MINUS, 1'b0});
            if (radix == itrs_pkg::BASE_HEX)
            begin
                chars_due.push_back({itrs_pkg::CHAR_ZERO, 1'b0});
                chars_due.push_back({itrs_pkg::CHAR_X, 1'b0});
            end
            for (k = 0; k < digits.size(); k++)
                chars_due.push_back({digits[k], k == digits.size() - 1});
        endfunction

        task report_mismatch(input string msg);
            if (errors < MAX_REPORTS)
                $display("%0t ns: MISMATCH: %s", $realtime, msg);
            errors++;
        endtask

        // Compare one received character with the oldest expectation
        task check_char(input logic [itrs_pkg::TDATA_W-1:0] data, input logic tlast);
            text_char_t want;
            if (chars_due.size() == 0)
            begin
                report_mismatch($sformatf("character 0x%02h with nothing pending", data));
                return;
            end
            want = chars_due.pop_front();
            if (data[itrs_pkg::CHAR_W-1:0] !== want.ch)
                report_mismatch($sformatf("char 0x%02h, expected 0x%02h",
                                          data[itrs_pkg::CHAR_W-1:0], want.ch));
            if (data[itrs_pkg::TDATA_W-1:itrs_pkg::CHAR_W] !== '0)
                report_mismatch($sformatf("tdata padding 0x%0h not zero",
                                          data[itrs_pkg::TDATA_W-1:itrs_pkg::CHAR_W]));
            if (tlast !== want.last)
                report_mismatch($sformatf("tlast %b, expected %b on char 0x%02h",
                                          tlast, want.last, want.ch));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals, clock and DUT
    // ------------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [itrs_pkg::VALUE_BITS-1:0] s_tdata;    // [31:0] value
    logic                            m_tvalid;
    logic                            m_tready;
    logic [itrs_pkg::TDATA_W-1:0]    m_tdata;    // [6:0] ascii_char, [7] zero
    logic                            m_tlast;
    logic                            cfg_wen;
    logic [itrs_pkg::BASE_W-1:0]     cfg_wdata;

    radix_text_board sb;
    int              tx_idle_pct   = 0;
    int              rx_idle_pct   = 0;
    int              rx_hold_asked = 0;
    int              rx_hold_served = 0;
    int              quiet_cycles  = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    integer_to_radix_string dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Output side: random stalls, plus a long hold-off when asked for
    // ------------------------------------------------------------------------
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_asked != rx_hold_served)
            begin
                rx_hold_served++;
                repeat (HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    @(posedge clk);
                end
            end
            m_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Transfer monitor: note accepted values, check accepted characters
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_value(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_char(m_tdata, m_tlast);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("integer_to_radix_string test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    // Offer one value, with random gaps before it, until it is taken
    task automatic send_value(input logic [itrs_pkg::VALUE_BITS-1:0] v);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Stop offering and wait until every expected character has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_base(input logic [itrs_pkg::BASE_W-1:0] b);
        cfg_wen   <= 1'b1;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        sb.set_base(b);
    endtask

    // Directed values: extremes, zero, letter digits, hex prefix, clamped bases
    directed_t directed_list[22] = '{
        '{6'd10, 32'h0000_0000}, '{6'd10, 32'h0000_0001}, '{6'd10, 32'hffff_ffff},
        '{6'd10, 32'h0000_0009}, '{6'd10, 32'h0000_000a}, '{6'd10, 32'h7fff_ffff},
        '{6'd10, 32'h8000_0000},
        '{6'd16, 32'h0000_0000}, '{6'd16, 32'hffff_ffff}, '{6'd16, 32'h8000_0000},
        '{6'd16, 32'h7fff_ffff}, '{6'd16, 32'h00ab_cdef},
        '{6'd0,  32'h8000_0000}, '{6'd0,  32'h7fff_ffff}, '{6'd0,  32'hffff_ffff},
        '{6'd63, 32'h0000_0023}, '{6'd63, 32'h0000_0024}, '{6'd63, 32'h8000_0000},
        '{6'd63, 32'hffff_ffdd},
        '{6'd1,  32'h0000_0000},
        '{6'd36, 32'h0000_0023},
        '{6'd37, 32'h0000_050f}
    };

    logic [itrs_pkg::BASE_W-1:0] phase_bases[RAND_PHASES] = '{
        6'd16, 6'd2, 6'd36, 6'd10, 6'd8, 6'd45, 6'd16, 6'd3, 6'd35, 6'd1, 6'd20, 6'd7
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [itrs_pkg::VALUE_BITS-1:0] v;
        logic [itrs_pkg::BASE_W-1:0]     b;
        int                              ph;
        int                              i;

        sb = new();
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling; rewrite the base whenever it changes
        for (i = 0; i < $size(directed_list); i++)
        begin
            if (i == 0 || directed_list[i].base != directed_list[i-1].base)
            begin
                if (i != 0)
                    wait_drained();
                write_base(directed_list[i].base);
            end
            send_value(directed_list[i].value);
        end

        // Random part: three idling regimes, a fresh base per phase
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drained();
            b = (ph % 3 == 2) ? itrs_pkg::BASE_W'($urandom_range(0, 63)) : phase_bases[ph];
            write_base(b);
            if (ph < 4)
            begin
                tx_idle_pct = 20;
                rx_idle_pct = 77;
            end
            else if (ph < 8)
            begin
                tx_idle_pct = 77;
                rx_idle_pct = 20;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // long output hold-off while values keep coming
                if (i == 5 && (ph == 1 || ph == 9))
                    rx_hold_asked <= rx_hold_asked + 1;
                case ($urandom_range(0, 3))
                    0: v = $urandom;
                    1: v = itrs_pkg::VALUE_BITS'($urandom_range(0, 80));
                    2: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                                : 32'h7fff_ffff - $urandom_range(0, 3);
                    default: v = $urandom >> $urandom_range(0, 31);
                endcase
                if ($urandom_range(0, 1) && v != 32'h8000_0000)
                    v = -v;
                send_value(v);
            end
        end

        wait_drained();
        if (sb.errors == 0)
            $display("integer_to_radix_string test passed");
        else
            $display("integer_to_radix_string test failed");
        $finish;
    end

endmodule
